// ===== rtl/pfds_pkg.sv =====
`default_nettype none

package pfds_pkg;

    localparam int CLK_W   = 30;
    localparam int FREQ_W  = 30;
    localparam int DUTY_W  = 17;
    localparam int DIV16_W = 12;
    localparam int Q1_W    = 12;
    localparam int Q2_W    = 17;
    localparam int WRAP_W  = 16;
    localparam int N_W     = 31;
    localparam int NUM_W   = 34;
    localparam int DEN_W   = 42;

    localparam logic [CLK_W-1:0]   SYS_CLOCK_RESET = 30'd125000000;
    localparam logic [DUTY_W-1:0]  DUTY_FULL       = 17'd65536;
    localparam logic [DIV16_W-1:0] DIV16_MIN       = 12'd16;
    localparam logic [DIV16_W-1:0] DIV16_MAX       = 12'd4095;
    localparam logic [WRAP_W-1:0]  WRAP_MAX        = 16'd65535;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_SYS_CLOCK = 1'b0;

    localparam int IN_DEPTH_DEFAULT  = 2;
    localparam int OUT_DEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_hz;
        logic [DUTY_W-1:0] duty_q16;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        div_integer;
        logic [3:0]        div_fraction;
        logic [WRAP_W-1:0] wrap_value;
        logic [WRAP_W-1:0] compare_level;
        status_t           status;
    } out_item_t;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        logic              zero;
        logic [DUTY_W-1:0] duty;
        logic [FREQ_W-1:0] hz;
        logic [CLK_W-1:0]  clk;
        logic [N_W-1:0]    n;
    } task_t;

endpackage

`default_nettype wire

// ===== rtl/pfds_fifo.sv =====
`default_nettype none

module pfds_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfds_front.sv =====
`default_nettype none

// Classifies a request: zero frequency, duty clamp and the rounded-up
// numerator for the divider quotient.
module pfds_front (
    input  wire pfds_pkg::in_item_t         req,
    input  wire logic [pfds_pkg::CLK_W-1:0] sys_clock,
    output pfds_pkg::task_t                 tsk
);

    logic [pfds_pkg::N_W-1:0] clk_up;
    logic [18:0]              clk_4k;

    // ceil(clock / 4096) followed by a ceiling division by hz later on
    assign clk_up = {1'b0, sys_clock} + pfds_pkg::N_W'(4095);
    assign clk_4k = clk_up[30:12];

    always_comb
    begin
        tsk.zero = (req.freq_hz == '0);
        tsk.duty = (req.duty_q16 > pfds_pkg::DUTY_FULL) ? pfds_pkg::DUTY_FULL : req.duty_q16;
        tsk.hz   = req.freq_hz;
        tsk.clk  = sys_clock;
        tsk.n    = pfds_pkg::N_W'(clk_4k) + pfds_pkg::N_W'(req.freq_hz) - 1'b1;
    end

endmodule

`default_nettype wire

// ===== rtl/pfds_back.sv =====
`default_nettype none

// Divider pipeline: one quotient bit per stage for both divisions.
module pfds_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire pfds_pkg::task_t   tsk,
    output logic                   in_pop,
    input  wire logic              out_full,
    output logic                   out_push,
    output pfds_pkg::out_item_t    out_item
);

    typedef struct packed {
        logic                          zero;
        logic [pfds_pkg::DUTY_W-1:0]   duty;
        logic [pfds_pkg::FREQ_W-1:0]   hz;
        logic [pfds_pkg::CLK_W-1:0]    clk;
        logic                          ovf;
        logic [pfds_pkg::N_W-1:0]      rem;
        logic [pfds_pkg::Q1_W-1:0]     q;
    } div1_t;

    typedef struct packed {
        logic                          zero;
        logic [pfds_pkg::DUTY_W-1:0]   duty;
        logic                          rng;
        logic [pfds_pkg::DIV16_W-1:0]  div16;
        logic [pfds_pkg::DEN_W-1:0]    d;
        logic                          ovf;
        logic [pfds_pkg::NUM_W-1:0]    rem;
        logic [pfds_pkg::Q2_W-1:0]     q;
    } div2_t;

    typedef struct packed {
        logic                          zero;
        logic [pfds_pkg::DUTY_W-1:0]   duty;
        logic                          rng;
        logic [pfds_pkg::DIV16_W-1:0]  div16;
        logic [pfds_pkg::WRAP_W-1:0]   wrap;
    } wrap_t;

    localparam int S1_N   = pfds_pkg::Q1_W + 1;
    localparam int S2_N   = pfds_pkg::Q2_W + 2;
    localparam int STAGES = S1_N + S2_N + 2;

    function automatic div1_t div1_step(div1_t s, int unsigned k);
        div1_t       r;
        logic [42:0] t;
        r = s;
        t = {13'b0, s.hz} << k;
        if ({12'b0, s.rem} >= t)
        begin
            r.rem = s.rem - t[pfds_pkg::N_W-1:0];
            r.q   = s.q | (pfds_pkg::Q1_W'(1) << k);
        end
        return r;
    endfunction

    function automatic div2_t div2_step(div2_t s, int unsigned k);
        div2_t       r;
        logic [58:0] t;
        r = s;
        t = {17'b0, s.d} << k;
        if ({25'b0, s.rem} >= t)
        begin
            r.rem = s.rem - t[pfds_pkg::NUM_W-1:0];
            r.q   = s.q | (pfds_pkg::Q2_W'(1) << k);
        end
        return r;
    endfunction

    div1_t               s1_reg [S1_N];
    div1_t               s1_next [S1_N];
    div2_t               s2_reg [S2_N];
    div2_t               s2_next [S2_N];
    wrap_t               s3_reg, s3_next;
    pfds_pkg::out_item_t s4_reg, s4_next;
    logic [STAGES-1:0]   vld_reg, vld_next;
    logic                adv;

    logic [pfds_pkg::DIV16_W-1:0] div16_c;
    logic [32:0]                  level_prod;

    assign adv      = !vld_reg[STAGES-1] || !out_full;
    assign in_pop   = adv && in_valid;
    assign out_push = adv && vld_reg[STAGES-1];
    assign out_item = s4_reg;
    assign vld_next = {vld_reg[STAGES-2:0], in_valid};

    always_comb
    begin
        s1_next[0].zero = tsk.zero;
        s1_next[0].duty = tsk.duty;
        s1_next[0].hz   = tsk.hz;
        s1_next[0].clk  = tsk.clk;
        s1_next[0].ovf  = ({12'b0, tsk.n} >= {1'b0, tsk.hz, 12'b0});
        s1_next[0].rem  = tsk.n;
        s1_next[0].q    = '0;
        for (int i = 0; i < pfds_pkg::Q1_W; i++)
        begin
            s1_next[i + 1] = div1_step(s1_reg[i], pfds_pkg::Q1_W - 1 - i);
        end
    end

    // Divider in sixteenths: saturate high, raise to the minimum
    always_comb
    begin
        if (s1_reg[S1_N-1].ovf)
        begin
            div16_c = pfds_pkg::DIV16_MAX;
        end
        else if (s1_reg[S1_N-1].q < pfds_pkg::DIV16_MIN)
        begin
            div16_c = pfds_pkg::DIV16_MIN;
        end
        else
        begin
            div16_c = s1_reg[S1_N-1].q;
        end
    end

    always_comb
    begin
        s2_next[0].zero  = s1_reg[S1_N-1].zero;
        s2_next[0].duty  = s1_reg[S1_N-1].duty;
        s2_next[0].rng   = s1_reg[S1_N-1].ovf;
        s2_next[0].div16 = div16_c;
        s2_next[0].d     = pfds_pkg::DEN_W'(div16_c) * pfds_pkg::DEN_W'(s1_reg[S1_N-1].hz);
        s2_next[0].ovf   = 1'b0;
        s2_next[0].rem   = {s1_reg[S1_N-1].clk, 4'b0};
        s2_next[0].q     = '0;
        s2_next[1]       = s2_reg[0];
        s2_next[1].ovf   = ({25'b0, s2_reg[0].rem} >= {s2_reg[0].d, 17'b0});
        for (int j = 0; j < pfds_pkg::Q2_W; j++)
        begin
            s2_next[j + 2] = div2_step(s2_reg[j + 1], pfds_pkg::Q2_W - 1 - j);
        end
    end

    always_comb
    begin
        s3_next.zero  = s2_reg[S2_N-1].zero;
        s3_next.duty  = s2_reg[S2_N-1].duty;
        s3_next.div16 = s2_reg[S2_N-1].div16;
        s3_next.rng   = s2_reg[S2_N-1].rng;
        if (s2_reg[S2_N-1].ovf || (s2_reg[S2_N-1].q > pfds_pkg::Q2_W'(65536)))
        begin
            s3_next.wrap = pfds_pkg::WRAP_MAX;
            s3_next.rng  = 1'b1;
        end
        else if (s2_reg[S2_N-1].q == '0)
        begin
            s3_next.wrap = '0;
            s3_next.rng  = 1'b1;
        end
        else
        begin
            s3_next.wrap = pfds_pkg::WRAP_W'(s2_reg[S2_N-1].q - 1'b1);
        end
    end

    assign level_prod = 33'(s3_reg.wrap) * 33'(s3_reg.duty);

    always_comb
    begin
        if (s3_reg.zero)
        begin
            s4_next               = '0;
            s4_next.status        = pfds_pkg::ST_IGNORED;
        end
        else
        begin
            s4_next.div_integer   = s3_reg.div16[11:4];
            s4_next.div_fraction  = s3_reg.div16[3:0];
            s4_next.wrap_value    = s3_reg.wrap;
            s4_next.compare_level = level_prod[31:16];
            s4_next.status        = s3_reg.rng ? pfds_pkg::ST_RANGE : pfds_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pwm_freq_duty_solver_core.sv =====
`default_nettype none

// PWM frequency and duty solver. Each item carries a frequency in hertz and a
// Q1.16 duty; each result gives the 8.4 clock divider, the counter wrap, the
// compare level and a status (ok, ignored for zero frequency, or out of range
// and saturated). Items enter through a small input queue and results leave
// through a small output queue, so both sides behave as FIFOs. The block takes
// one item per clock cycle in steady state while the output queue has room,
// because every step of the work is its own pipeline stage. The back end is
// 34 stages deep: thirteen for the clock divider (a load stage and one stage
// per quotient bit), nineteen for the wrap quotient (a load stage that also
// forms the divisor product, an overflow check and seventeen quotient bits),
// one stage that saturates the wrap and one that forms the compare level. An
// item goes from the input queue through these stages in that order into the
// output queue. The whole pipeline holds still while its last stage has a
// result and the output queue is full, so items are only delayed, never lost.
// The system clock register lives at byte address 0 of the APB port and
// should be written only while no item is in flight.
module pwm_freq_duty_solver_core #(
    parameter int IN_DEPTH  = pfds_pkg::IN_DEPTH_DEFAULT,
    parameter int OUT_DEPTH = pfds_pkg::OUT_DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire pfds_pkg::in_item_t  req,
    output logic                     full,
    input  wire logic                pop,
    output pfds_pkg::out_item_t      rsp,
    output logic                     empty,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [pfds_pkg::CLK_W-1:0] sys_clock_reg, sys_clock_next;
    logic                       cfg_wr;

    pfds_pkg::task_t     tsk_in, tsk_out;
    logic                q_empty, q_pop;
    logic                bk_push, out_full;
    pfds_pkg::out_item_t bk_item;

    // Configuration: a single register, the system clock in hertz.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == pfds_pkg::REG_SYS_CLOCK);
    assign prdata = (paddr[2] == pfds_pkg::REG_SYS_CLOCK) ? {2'b0, sys_clock_reg} : '0;
    assign sys_clock_next = cfg_wr ? pwdata[pfds_pkg::CLK_W-1:0] : sys_clock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_clock_reg <= pfds_pkg::SYS_CLOCK_RESET;
        end
        else
        begin
            sys_clock_reg <= sys_clock_next;
        end
    end

    // Front end: classify each item as it is accepted.
    pfds_front u_front (
        .req       (req),
        .sys_clock (sys_clock_reg),
        .tsk       (tsk_in)
    );

    // Short queue between front end and divider pipeline; its full flag is
    // the input side's back-pressure.
    pfds_fifo #(
        .WIDTH ($bits(pfds_pkg::task_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (tsk_in),
        .full  (full),
        .pop   (q_pop),
        .rdata (tsk_out),
        .empty (q_empty)
    );

    // Back end: the two bit-serial-per-stage dividers and the multiplies.
    pfds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .tsk      (tsk_out),
        .in_pop   (q_pop),
        .out_full (out_full),
        .out_push (bk_push),
        .out_item (bk_item)
    );

    // Result queue; while it is full and the last stage holds a result, new items wait.
    pfds_fifo #(
        .WIDTH ($bits(pfds_pkg::out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_push),
        .wdata (bk_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (rsp),
        .empty (empty)
    );

    // The pipeline must never present an item to a full result queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        bk_push |-> !out_full)
        else $error("result item pushed into a full queue");

    // An ignored request carries all-zero fields.
    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status == pfds_pkg::ST_IGNORED) |->
        (rsp.div_integer == '0 && rsp.div_fraction == '0 &&
         rsp.wrap_value == '0 && rsp.compare_level == '0))
        else $error("ignored item with non-zero fields");

    // A successful result never has a divider below one.
    a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status == pfds_pkg::ST_OK) |-> (rsp.div_integer != '0))
        else $error("divider below minimum on an ok item");

    // The compare level never exceeds the wrap.
    a_level_le_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rsp.compare_level <= rsp.wrap_value))
        else $error("compare level above wrap");

endmodule

`default_nettype wire
